/* rtl/four_level_page_table_walker_defines.svh */
// Assertion macros for the page-table walker.
// Included by the top level; depends on nothing else.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

`ifndef ASSERT_OFF

`define PTW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("page table walker check failed");

`define PTW_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("page table walker forbidden condition");

`else

`define PTW_ASSERT(lbl, clk, rst_n, prop)

`define PTW_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

/* rtl/ptw_pkg.sv */
// Shared types and constants for the page-table walker.
// Used by every module of the block; depends on nothing.
package ptw_pkg;

    localparam int TABLE_WORDS_DEF = 32768;
    localparam int LEVELS_DEF      = 4;

    localparam int WORDS_PER_PAGE = 512;
    localparam int SLOT_W         = 9;
    localparam int OFFSET_W       = 12;
    localparam int VA_W           = 48;
    localparam int PAGE_W         = 40;
    localparam int ENTRY_W        = 64;
    localparam int ROOT_W         = 6;
    localparam int WIDX_W         = 15;

    localparam int ENT_P_BIT = 0;
    localparam int ENT_W_BIT = 1;
    localparam int ENT_U_BIT = 2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_XLATE = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [WIDX_W-1:0]   table_word_index;
        logic [ENTRY_W-1:0]  entry_value;
        logic [VA_W-1:0]     virt_addr;
    } in_item_t;

    typedef struct packed {
        logic                mapped;
        logic [PAGE_W-1:0]   page_number;
        logic [51:0]         phys_addr;
        logic [11:0]         permissions;
    } out_item_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_PEND
    } walk_state_t;

endpackage

/* rtl/ptw_table_mem.sv */
// Single-port table memory of 64-bit entry words with a registered read.
// Depends on ptw_pkg for the control struct.
module ptw_table_mem #(
    parameter int DEPTH = ptw_pkg::TABLE_WORDS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  ptw_pkg::mem_ctl_t             ctl,
    input  logic [AW-1:0]                 addr,
    input  logic [ptw_pkg::ENTRY_W-1:0]   wr_data,
    output logic [ptw_pkg::ENTRY_W-1:0]   rd_data
);
    import ptw_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        else if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/ptw_walk.sv */
// Walk sequencer: takes items, drives the table memory level by level and
// forms the result. Depends on ptw_pkg.
module ptw_walk #(
    parameter int TABLE_WORDS = ptw_pkg::TABLE_WORDS_DEF,
    parameter int LEVELS      = ptw_pkg::LEVELS_DEF,
    parameter int AW          = $clog2(TABLE_WORDS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  ptw_pkg::in_item_t             item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output ptw_pkg::out_item_t            result,
    input  logic [ptw_pkg::ROOT_W-1:0]    root_table_page,
    output ptw_pkg::mem_ctl_t             mem_ctl,
    output logic [AW-1:0]                 mem_addr,
    output logic [ptw_pkg::ENTRY_W-1:0]   mem_wr_data,
    input  logic [ptw_pkg::ENTRY_W-1:0]   mem_rd_data
);
    import ptw_pkg::*;

    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PAGES     = TABLE_WORDS / WORDS_PER_PAGE;
    localparam int VA_EXT_W  = (OFFSET_W + SLOT_W * LEVELS > VA_W) ?
                               OFFSET_W + SLOT_W * LEVELS : VA_W;

    walk_state_t        state_reg, state_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic [1:0]         acc_wu_reg, acc_wu_next;
    logic [VA_W-1:0]    va_reg, va_next;
    out_item_t          res_reg, res_next;
    out_item_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               accept;
    logic               out_free;
    logic               issue;
    logic               finish;
    out_item_t          fin_res;
    logic [ENTRY_W-1:0] entry_now;
    logic               present;
    logic               last;
    logic [PAGE_W-1:0]  next_page;
    logic               next_ok;
    logic               root_ok;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [VA_W-1:0] va,
                                                  input logic [LVL_W-1:0] lvl);
        logic [VA_EXT_W-1:0] va_ext;
        logic [SLOT_W-1:0]   slot;
        va_ext = VA_EXT_W'(va);
        slot   = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (lvl == LVL_W'(i))
            begin
                slot = va_ext[OFFSET_W + SLOT_W * (LEVELS - 1 - i) +: SLOT_W];
            end
        end
        return slot;
    endfunction

    function automatic logic [AW-1:0] word_addr(input logic [PAGE_W-1:0] page,
                                                input logic [SLOT_W-1:0] slot);
        logic [AW+SLOT_W-1:0] full;
        full = {AW'(page), slot};
        return full[AW-1:0];
    endfunction

    function automatic logic page_ok(input logic [PAGE_W-1:0] page);
        return page < PAGE_W'(PAGES);
    endfunction

    assign accept   = item_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !result_stall;

    // The writable and user bits are narrowed by every level walked so far.
    always_comb
    begin
        entry_now = mem_rd_data;
        entry_now[ENT_W_BIT] = mem_rd_data[ENT_W_BIT] & acc_wu_reg[0];
        entry_now[ENT_U_BIT] = mem_rd_data[ENT_U_BIT] & acc_wu_reg[1];
    end

    assign present   = entry_now[ENT_P_BIT];
    assign last      = (level_reg == LVL_W'(LEVELS - 1));
    assign next_page = entry_now[51:12];
    assign next_ok   = present && !last && page_ok(next_page);
    assign root_ok   = page_ok(PAGE_W'(root_table_page));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (issue)
                begin
                    state_next = ST_WAIT;
                end
                else if (finish && !out_free)
                begin
                    state_next = ST_PEND;
                end
            end
            ST_WAIT:
            begin
                if (!issue)
                begin
                    state_next = out_free ? ST_IDLE : ST_PEND;
                end
            end
            ST_PEND:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall     = (state_reg != ST_IDLE);
        mem_ctl        = '0;
        mem_addr       = AW'(item.table_word_index);
        mem_wr_data    = item.entry_value;
        issue          = 1'b0;
        finish         = 1'b0;
        fin_res        = '0;
        level_next     = level_reg;
        acc_wu_next    = acc_wu_reg;
        va_next        = va_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.kind == KIND_WRITE)
                    begin
                        mem_ctl.wr_en = (32'(item.table_word_index) < 32'(TABLE_WORDS));
                        finish        = 1'b1;
                    end
                    else if (root_ok)
                    begin
                        mem_ctl.rd_en = 1'b1;
                        mem_addr      = word_addr(PAGE_W'(root_table_page),
                                                  slot_of(item.virt_addr, '0));
                        issue         = 1'b1;
                        level_next    = '0;
                        acc_wu_next   = 2'b11;
                        va_next       = item.virt_addr;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            ST_WAIT:
            begin
                if (next_ok)
                begin
                    mem_ctl.rd_en = 1'b1;
                    mem_addr      = word_addr(next_page, slot_of(va_reg, level_reg + 1'b1));
                    issue         = 1'b1;
                    level_next    = level_reg + 1'b1;
                    acc_wu_next   = {entry_now[ENT_U_BIT], entry_now[ENT_W_BIT]};
                end
                else
                begin
                    finish = 1'b1;
                    if (present && last)
                    begin
                        fin_res.mapped      = 1'b1;
                        fin_res.page_number = entry_now[51:12];
                        fin_res.phys_addr   = {entry_now[51:12], va_reg[OFFSET_W-1:0]};
                        fin_res.permissions = entry_now[11:0];
                    end
                end
            end
            ST_PEND:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (finish)
        begin
            if (out_free)
            begin
                out_next       = fin_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                res_next = fin_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            level_reg     <= '0;
            acc_wu_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            acc_wu_reg    <= acc_wu_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg  <= va_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* rtl/four_level_page_table_walker.sv */
// Page-table walker over a local table memory: top level.
// Holds the root-page register and joins ptw_walk and ptw_table_mem.
// Depends on ptw_pkg and four_level_page_table_walker_defines.svh.
//
// Usage:
//   The item channel (item_valid, item_stall, item) carries write and
//   translate items; the result channel (result_valid, result_stall, result)
//   returns exactly one result per item, in order.
//   A write item stores one entry word at its transfer edge; its all-zero
//   result is loaded into the output register in the same edge, so writes
//   run at one item per cycle while the receiver keeps up.
//   A translate item performs one table memory read per level, each read
//   registered in the memory; the walk stops early if a level is not
//   present, and the block takes no new item until the walk is through.
//   The single read port of the table memory and the dependence of each
//   level on the previous entry keep the reads in sequence.
//   The root table page is written through cfg_wr_en / cfg_wr_data while
//   the block is idle; the user must keep to this, the block does not enforce it.
//   Reset clears the walk state, the output valid flag and the root page; the
//   table memory is not cleared and must be written before it is walked.
//   When the receiver stalls, a finished result is parked and the block
//   stalls further items until it has been moved out.
module four_level_page_table_walker #(
    parameter int TABLE_WORDS = ptw_pkg::TABLE_WORDS_DEF,
    parameter int LEVELS      = ptw_pkg::LEVELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  ptw_pkg::in_item_t             item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output ptw_pkg::out_item_t            result,
    input  logic                          cfg_wr_en,
    input  logic [ptw_pkg::ROOT_W-1:0]    cfg_wr_data
);
    import ptw_pkg::*;

`include "four_level_page_table_walker_defines.svh"

    localparam int AW = $clog2(TABLE_WORDS);

    logic [ROOT_W-1:0]  root_reg, root_next;
    mem_ctl_t           mem_ctl;
    logic [AW-1:0]      mem_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic [ENTRY_W-1:0] mem_rd_data;

    assign root_next = cfg_wr_en ? cfg_wr_data : root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
        end
        else
        begin
            root_reg <= root_next;
        end
    end

    ptw_walk #(
        .TABLE_WORDS (TABLE_WORDS),
        .LEVELS      (LEVELS),
        .AW          (AW)
    ) u_walk (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .root_table_page (root_reg),
        .mem_ctl         (mem_ctl),
        .mem_addr        (mem_addr),
        .mem_wr_data     (mem_wr_data),
        .mem_rd_data     (mem_rd_data)
    );

    ptw_table_mem #(
        .DEPTH (TABLE_WORDS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .addr    (mem_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    // The memory port is shared, so a write and a walk read never coincide.
    `PTW_ASSERT_NEVER(a_no_rw_overlap, clk, rst_n, mem_ctl.wr_en && mem_ctl.rd_en)
    // Table words change only at the transfer of a write item.
    `PTW_ASSERT(a_write_on_transfer, clk, rst_n, mem_ctl.wr_en |-> (item_valid && !item_stall && item.kind == KIND_WRITE))
    // While read data is on its way back, no further item is taken.
    `PTW_ASSERT(a_stall_during_walk, clk, rst_n, mem_ctl.rd_en |=> item_stall)

endmodule

/* test/tb_four_level_page_table_walker.sv */
// Self-checking testbench for four_level_page_table_walker: builds page tables through
// write transfers, translates directed and random addresses and checks every result.
// Depends on ptw_pkg and the RTL of the walker.
module tb_four_level_page_table_walker;
    timeunit 1ns;
    timeprecision 1ps;

    import ptw_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TABLE_PAGES = TABLE_WORDS_DEF / WORDS_PER_PAGE;
    localparam logic [ENTRY_W-1:0] CARRY_BITS = (64'd1 << ENT_W_BIT) | (64'd1 << ENT_U_BIT);

    typedef logic [ENTRY_W-1:0] word_store_t [int];

    // Expected results in transfer order, predicted from a private copy of table memory.
    class walk_scoreboard;
        word_store_t table_words;
        logic [ROOT_W-1:0] root_page;
        out_item_t expected_q[$];
        int errors;

        function new();
            root_page = '0;
            errors = 0;
        endfunction

        // Walks the tables held in words. missing_idx returns the first word read that
        // was never written (-1 if none) and missing_lvl the level that read it.
        static function out_item_t walk_tables(ref word_store_t words,
                                               input logic [ROOT_W-1:0] root,
                                               input logic [VA_W-1:0] va,
                                               output int missing_idx,
                                               output int missing_lvl);
            out_item_t res;
            logic [ENTRY_W-1:0] ent;
            logic [ENTRY_W-1:0] word;
            logic [PAGE_W-1:0] pg;
            logic [SLOT_W-1:0] slot;
            bit present;
            int idx;
            res = '0;
            ent = CARRY_BITS | (64'd1 << ENT_P_BIT);
            pg = PAGE_W'(root);
            present = 1'b1;
            missing_idx = -1;
            missing_lvl = 0;
            for (int lvl = 0; lvl < LEVELS_DEF; lvl++)
            begin
                if (present)
                begin
                    slot = va[OFFSET_W + SLOT_W * (LEVELS_DEF - 1 - lvl) +: SLOT_W];
                    if (pg >= TABLE_PAGES)
                    begin
                        present = 1'b0;
                    end
                    else
                    begin
                        idx = int'(pg) * WORDS_PER_PAGE + int'(slot);
                        if (words.exists(idx))
                        begin
                            word = words[idx];
                        end
                        else
                        begin
                            word = '0;
                            missing_idx = idx;
                            missing_lvl = lvl;
                        end
                        // Writable and user only survive if every level above had them.
                        ent = word & (~CARRY_BITS | (ent & CARRY_BITS));
                        present = ent[ENT_P_BIT];
                        pg = ent[51:12];
                    end
                end
            end
            if (present)
            begin
                res.mapped = 1'b1;
                res.page_number = ent[51:12];
                res.phys_addr = {ent[51:12], va[OFFSET_W-1:0]};
                res.permissions = ent[11:0];
            end
            return res;
        endfunction

        function void set_root(logic [ROOT_W-1:0] page);
            root_page = page;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_item(in_item_t it);
            int miss_idx;
            int miss_lvl;
            if (it.kind == KIND_WRITE)
            begin
                table_words[int'(it.table_word_index)] = it.entry_value;
                expected_q.push_back('0);
            end
            else
            begin
                expected_q.push_back(walk_tables(table_words, root_page, it.virt_addr,
                                                 miss_idx, miss_lvl));
            end
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result with nothing outstanding", 64'(got.page_number), 0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.mapped !== want.mapped)
                    report_mismatch("mapped", 64'(got.mapped), 64'(want.mapped));
                if (got.page_number !== want.page_number)
                    report_mismatch("page_number", 64'(got.page_number),
                                    64'(want.page_number));
                if (got.phys_addr !== want.phys_addr)
                    report_mismatch("phys_addr", 64'(got.phys_addr), 64'(want.phys_addr));
                if (got.permissions !== want.permissions)
                    report_mismatch("permissions", 64'(got.permissions),
                                    64'(want.permissions));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    in_item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    out_item_t result;
    logic cfg_wr_en = 1'b0;
    logic [ROOT_W-1:0] cfg_wr_data = '0;

    walk_scoreboard sb = new();
    word_store_t table_shadow;
    logic [VA_W-1:0] va_history[$];
    int items_sent = 0;
    int hold_cycles = 0;
    int cycle_count = 0;
    bit tx_gaps_on = 1'b0;
    bit rx_stalls_on = 1'b0;

    four_level_page_table_walker u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #5ns clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(result);
            if (item_valid && !item_stall)
                sb.note_item(item);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_four_level_page_table_walker failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus a long hold-off when the sender asks for one.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                result_stall <= 1'b0;
            end
            else if (rx_stalls_on && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Entry for a table word that a walk is about to read for the first time.
    function automatic logic [ENTRY_W-1:0] fresh_entry(int lvl);
        logic [ENTRY_W-1:0] e;
        int r;
        e = rand64();
        r = $urandom_range(0, 99);
        if (lvl == LEVELS_DEF - 1)
        begin
            e[ENT_P_BIT] = (r >= 10);
        end
        else if (r < 8)
        begin
            e[ENT_P_BIT] = 1'b0;
        end
        else
        begin
            e[ENT_P_BIT] = 1'b1;
            if (r < 11)
                e[51:12] = 40'(TABLE_PAGES);
            else if (r < 15)
            begin
                if (e[51:18] == '0)
                    e[51] = 1'b1;
            end
            else if (r < 60)
                e[51:12] = 40'($urandom_range(0, 3));
            else
                e[51:12] = 40'($urandom_range(0, TABLE_PAGES - 1));
            if ($urandom_range(0, 3) != 0)
                e = e | CARRY_BITS;
        end
        return e;
    endfunction

    task automatic send_item(input in_item_t it);
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        if (tx_gaps_on && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic issue_write(input logic [WIDX_W-1:0] idx, input logic [ENTRY_W-1:0] val);
        in_item_t it;
        it.kind = KIND_WRITE;
        it.table_word_index = idx;
        it.entry_value = val;
        it.virt_addr = VA_W'(rand64());
        table_shadow[int'(idx)] = val;
        send_item(it);
    endtask

    // Writes every table word the walk would read unwritten, then sends the translation.
    task automatic issue_translate(input logic [VA_W-1:0] va);
        int miss_idx;
        int miss_lvl;
        in_item_t it;
        miss_idx = 0;
        while (miss_idx >= 0)
        begin
            void'(walk_scoreboard::walk_tables(table_shadow, sb.root_page, va,
                                               miss_idx, miss_lvl));
            if (miss_idx >= 0)
                issue_write(WIDX_W'(miss_idx), fresh_entry(miss_lvl));
        end
        it.kind = KIND_XLATE;
        it.table_word_index = WIDX_W'($urandom);
        it.entry_value = rand64();
        it.virt_addr = va;
        send_item(it);
    endtask

    task automatic noise_write();
        logic [WIDX_W-1:0] idx;
        idx = WIDX_W'($urandom);
        if ($urandom_range(0, 1) == 0)
            idx[WIDX_W-1:SLOT_W] = 6'($urandom_range(0, 3));
        issue_write(idx, fresh_entry($urandom_range(0, LEVELS_DEF - 1)));
    endtask

    task automatic random_items(input int target);
        logic [VA_W-1:0] va;
        int r;
        int lv;
        while (items_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                noise_write();
            end
            else
            begin
                if (va_history.size() == 0 || r < 40)
                begin
                    va = VA_W'(rand64());
                end
                else
                begin
                    // Reuse a known address so most walks run through tables already built.
                    va = va_history[$urandom_range(0, va_history.size() - 1)];
                    va[OFFSET_W-1:0] = OFFSET_W'($urandom);
                    if (r < 65)
                    begin
                        lv = $urandom_range(0, LEVELS_DEF - 1);
                        va[OFFSET_W + SLOT_W * lv +: SLOT_W] = SLOT_W'($urandom);
                    end
                end
                va_history.push_back(va);
                if (va_history.size() > 64)
                    void'(va_history.pop_front());
                issue_translate(va);
            end
        end
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_root(input logic [ROOT_W-1:0] page);
        cfg_wr_data <= page;
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_root(page);
    endtask

    task automatic run_directed();
        // Root page 0 slot 0 points far outside table memory.
        issue_write(15'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        issue_write(15'd32767, 64'hFFFF_FFFF_FFFF_FFFF);
        issue_write(15'd2, 64'h0);
        // Chain root 0 -> page 1 -> page 2 -> page 3, large-page bit set at the top.
        issue_write(15'd511, 64'h0000_0000_0000_1087);
        issue_write(15'd1023, 64'h0000_0000_0000_2007);
        issue_write(15'd512, 64'h0000_0000_0000_2001);
        issue_write(15'd1535, 64'h0000_0000_0000_3007);
        issue_write(15'd2047, 64'hFFFF_FFFF_FFFF_FFFF);
        issue_write(15'd1536, 64'hFFFF_FFFF_FFFF_FFFE);
        issue_translate(48'h0);
        issue_translate(48'hFFFF_FFFF_FFFF);
        issue_translate(48'h0100_0000_0000);
        issue_translate(48'hFFFF_FFE0_0000);
        // Middle level lacks writable and user.
        issue_translate(48'hFF80_3FFF_FABC);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        run_directed();
        drain();

        write_root(6'd63);
        random_items(230);
        drain();

        write_root(6'($urandom_range(0, TABLE_PAGES - 1)));
        tx_gaps_on = 1'b0;
        random_items(330);
        // Long receiver hold-off while writes keep coming, so the block backs up.
        hold_cycles = 100;
        repeat (40) noise_write();
        drain();
        tx_gaps_on = 1'b1;
        random_items(450);
        drain();

        write_root(6'd0);
        rx_stalls_on = 1'b0;
        random_items(670);
        drain();

        write_root(6'($urandom_range(0, TABLE_PAGES - 1)));
        rx_stalls_on = 1'b1;
        random_items(880);
        drain();

        write_root(6'($urandom_range(0, TABLE_PAGES - 1)));
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        random_items(1060);
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_four_level_page_table_walker passed");
        else
            $display("tb_four_level_page_table_walker failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/ptw_pkg.sv
rtl/ptw_table_mem.sv
rtl/ptw_walk.sv
rtl/four_level_page_table_walker.sv
test/tb_four_level_page_table_walker.sv
